### rtl/core/wsrl_pkg.sv
// Types and constants shared by the windowed send-rate limiter modules.
package wsrl_pkg;

  localparam int unsigned RATE_W    = 20;
  localparam int unsigned BYTES_W   = 16;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned TOTAL_W   = 19;
  localparam int unsigned DELTA_W   = 26;
  localparam int unsigned COUNT_W   = 32;
  localparam int unsigned ALU_W     = 32;
  localparam int unsigned DIV_STEPS = 26;
  localparam int unsigned DIV_CNT_W = 5;

  localparam logic [DELTA_W-1:0] MS_PER_SECOND = 26'd1000;

  typedef enum logic [1:0] {
    OP_RATE_CHECK  = 2'd0,
    OP_RECORD_SEND = 2'd1,
    OP_ADVANCE     = 2'd2,
    OP_PACE_QUERY  = 2'd3
  } op_e;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_SUM  = 7'b0000010,
    ST_CMP  = 7'b0000100,
    ST_DIV  = 7'b0001000,
    ST_DIFF = 7'b0010000,
    ST_PACE = 7'b0100000,
    ST_FIN  = 7'b1000000
  } state_e;

  typedef struct packed {
    logic [1:0]         operation;
    logic [BYTES_W-1:0] sent_bytes;
    logic [TIME_W-1:0]  now_ms;
    logic               is_spawned;
  } in_item_t;

  typedef struct packed {
    logic               suppressed;
    logic [TOTAL_W-1:0] window_total;
    logic               ready_res;
    logic [DELTA_W-1:0] pacing_delay;
    logic [COUNT_W-1:0] suppress_total;
    logic [COUNT_W-1:0] frame_count;
  } out_item_t;

  typedef struct packed {
    logic             sub;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] res;
    logic             carry;
  } alu_rsp_t;

endpackage

### rtl/core/wsrl_alu.sv
// Shared add and subtract unit; on subtraction the carry is set when a is at least b.
module wsrl_alu
  import wsrl_pkg::*;
(
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  logic [ALU_W:0] sum;

  assign sum = {1'b0, req_i.a} + {1'b0, req_i.b ^ {ALU_W{req_i.sub}}}
             + {{ALU_W{1'b0}}, req_i.sub};

  assign rsp_o.res   = sum[ALU_W-1:0];
  assign rsp_o.carry = sum[ALU_W];

endmodule

### rtl/core/wsrl_ring.sv
// Ring of recent frame sizes with per-entry valid bits and a registered read port.
module wsrl_ring
  import wsrl_pkg::*;
#(
  parameter int unsigned WINDOW = 8,
  parameter int unsigned IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  logic [IDX_W-1:0]   wr_addr_i,
  input  logic [BYTES_W-1:0] wr_data_i,
  input  logic               rd_en_i,
  input  logic [IDX_W-1:0]   rd_addr_i,
  output logic [BYTES_W-1:0] rd_data_o
);

  logic [BYTES_W-1:0] mem [WINDOW];
  logic [WINDOW-1:0]  valid_q;
  logic [BYTES_W-1:0] rd_q;
  logic               rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

### rtl/core/windowed_send_rate_limiter.sv
// Top level of the windowed send-rate limiter: sequencer, state and output register.
//
//  Channel  Direction  Handshake               Payload
//  in       input      in_valid_i / in_stall_o  in_data_i (in_item_t)
//  out      output     out_valid_o / out_stall_i out_data_o (out_item_t)
//  cfg      input      cfg_we_i                 cfg_wdata_i (byte rate)
//
// A rate check reads the ring and adds it into the sum one entry a cycle, then compares
// the sum with the rate. A record send with a nonzero rate runs the 26-step restoring
// division; an advance goes straight to finish and a pacing query through DIFF and PACE.
// Reset clears the ring valid bits, all counters, the rate and the output valid flag at once.
// A finished result waits in the output register while the next transaction is taken;
// the sequencer holds its last state only if that register is still occupied and stalled.
module windowed_send_rate_limiter
  import wsrl_pkg::*;
#(
  parameter int unsigned WINDOW = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [RATE_W-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_item_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_item_t         out_data_o
);

  localparam int unsigned IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CNT_W = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W = BYTES_W + CNT_W;
  localparam int unsigned EXT_W = SUM_W + TOTAL_W;

  state_e               state_q, state_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [SUM_W-1:0]     acc_q, acc_d;
  logic [RATE_W-1:0]    rem_q, rem_d;
  logic [DELTA_W-1:0]   quo_q, quo_d;
  logic [DIV_CNT_W-1:0] div_cnt_q, div_cnt_d;
  logic [TIME_W-1:0]    now_q, now_d;
  logic [TIME_W-1:0]    diff_q, diff_d;
  logic                 sup_q, sup_d;
  logic                 ready_q, ready_d;

  logic [RATE_W-1:0]    rate_q;
  logic [COUNT_W-1:0]   frame_q, frame_d;
  logic [IDX_W-1:0]     slot_q, slot_d;
  logic [TIME_W-1:0]    last_q, last_d;
  logic [DELTA_W-1:0]   delta_q, delta_d;
  logic [COUNT_W-1:0]   supp_q, supp_d;

  out_item_t            out_q, out_d;
  logic                 out_valid_q, out_valid_d;

  alu_req_t             alu_req;
  alu_rsp_t             alu_rsp;
  logic                 ring_wr_en;
  logic [IDX_W-1:0]     ring_wr_addr;
  logic [BYTES_W-1:0]   ring_wr_data;
  logic                 ring_rd_en;
  logic [IDX_W-1:0]     ring_rd_addr;
  logic [BYTES_W-1:0]   ring_rd_data;

  logic                 in_fire;
  logic [EXT_W-1:0]     total_ext;
  logic [RATE_W:0]      div_shift;

  wsrl_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  wsrl_ring #(
    .WINDOW (WINDOW),
    .IDX_W  (IDX_W)
  ) u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (ring_wr_en),
    .wr_addr_i (ring_wr_addr),
    .wr_data_i (ring_wr_data),
    .rd_en_i   (ring_rd_en),
    .rd_addr_i (ring_rd_addr),
    .rd_data_o (ring_rd_data)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign total_ext  = EXT_W'(acc_q);
  assign div_shift  = {rem_q, quo_q[DELTA_W-1]};

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    acc_d        = acc_q;
    rem_d        = rem_q;
    quo_d        = quo_q;
    div_cnt_d    = div_cnt_q;
    now_d        = now_q;
    diff_d       = diff_q;
    sup_d        = sup_q;
    ready_d      = ready_q;
    frame_d      = frame_q;
    slot_d       = slot_q;
    last_d       = last_q;
    delta_d      = delta_q;
    supp_d       = supp_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    alu_req      = '0;
    ring_wr_en   = 1'b0;
    ring_wr_addr = slot_q;
    ring_wr_data = '0;
    ring_rd_en   = 1'b0;
    ring_rd_addr = cnt_q[IDX_W-1:0];

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          sup_d   = 1'b0;
          ready_d = 1'b0;
          acc_d   = '0;
          cnt_d   = '0;
          unique case (op_e'(in_data_i.operation))
            OP_RATE_CHECK: begin
              state_d = ST_SUM;
            end
            OP_RECORD_SEND: begin
              last_d = in_data_i.now_ms;
              if (rate_q == '0) begin
                delta_d = '0;
                state_d = ST_FIN;
              end else begin
                ring_wr_en   = in_data_i.is_spawned;
                ring_wr_data = in_data_i.sent_bytes;
                quo_d        = DELTA_W'(in_data_i.sent_bytes) * MS_PER_SECOND;
                rem_d        = '0;
                div_cnt_d    = DIV_CNT_W'(DIV_STEPS - 1);
                state_d      = ST_DIV;
              end
            end
            OP_ADVANCE: begin
              frame_d = frame_q + COUNT_W'(1);
              slot_d  = ((slot_q == IDX_W'(WINDOW - 1)) || (frame_q == '1)) ?
                        '0 : slot_q + IDX_W'(1);
              state_d = ST_FIN;
            end
            OP_PACE_QUERY: begin
              now_d   = in_data_i.now_ms;
              state_d = ST_DIFF;
            end
            default: begin
              state_d = ST_FIN;
            end
          endcase
        end
      end
      ST_SUM: begin
        if (cnt_q != CNT_W'(WINDOW)) begin
          ring_rd_en = 1'b1;
        end
        if (cnt_q != '0) begin
          alu_req.a = ALU_W'(acc_q);
          alu_req.b = ALU_W'(ring_rd_data);
          acc_d     = alu_rsp.res[SUM_W-1:0];
        end
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(WINDOW)) begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        alu_req.sub = 1'b1;
        alu_req.a   = ALU_W'(rate_q);
        alu_req.b   = ALU_W'(acc_q);
        if ((rate_q != '0) && !alu_rsp.carry) begin
          sup_d      = 1'b1;
          supp_d     = supp_q + COUNT_W'(1);
          ring_wr_en = 1'b1;
        end
        state_d = ST_FIN;
      end
      ST_DIV: begin
        alu_req.sub = 1'b1;
        alu_req.a   = ALU_W'(div_shift);
        alu_req.b   = ALU_W'(rate_q);
        rem_d       = alu_rsp.carry ? alu_rsp.res[RATE_W-1:0] : div_shift[RATE_W-1:0];
        quo_d       = {quo_q[DELTA_W-2:0], alu_rsp.carry};
        if (div_cnt_q == '0) begin
          delta_d = {quo_q[DELTA_W-2:0], alu_rsp.carry};
          state_d = ST_FIN;
        end else begin
          div_cnt_d = div_cnt_q - DIV_CNT_W'(1);
        end
      end
      ST_DIFF: begin
        alu_req.sub = 1'b1;
        alu_req.a   = now_q;
        alu_req.b   = last_q;
        diff_d      = alu_rsp.res;
        state_d     = ST_PACE;
      end
      ST_PACE: begin
        alu_req.sub = 1'b1;
        alu_req.a   = diff_q;
        alu_req.b   = ALU_W'(delta_q);
        ready_d     = alu_rsp.carry;
        state_d     = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.suppressed     = sup_q;
          out_d.window_total   = total_ext[TOTAL_W-1:0];
          out_d.ready_res      = ready_q;
          out_d.pacing_delay   = delta_q;
          out_d.suppress_total = supp_q;
          out_d.frame_count    = frame_q;
          out_valid_d          = 1'b1;
          state_d              = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      div_cnt_q   <= '0;
      rate_q      <= '0;
      frame_q     <= '0;
      slot_q      <= '0;
      last_q      <= '0;
      delta_q     <= '0;
      supp_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      div_cnt_q   <= div_cnt_d;
      frame_q     <= frame_d;
      slot_q      <= slot_d;
      last_q      <= last_d;
      delta_q     <= delta_d;
      supp_q      <= supp_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        rate_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    now_q   <= now_d;
    diff_q  <= diff_d;
    sup_q   <= sup_d;
    ready_q <= ready_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_advance_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (op_e'(in_data_i.operation) == OP_ADVANCE)
      |=> frame_q == $past(frame_q) + COUNT_W'(1))
    else $error("advance transaction did not step the frame number");

  a_slot_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(slot_q) < WINDOW)
    else $error("ring slot pointer beyond the window");

  a_supp_from_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (supp_q != $past(supp_q)) |-> ($past(state_q) == ST_CMP))
    else $error("suppression count changed outside the rate compare step");

endmodule
